// ----- rtl/ostcs_pkg.sv -----
// ostcs_pkg: shared constants, action codes and node record type for the
// order statistic count and sum tree. No dependencies.

package ostcs_pkg;

   localparam int LEAVES     = 1024;
   localparam int NODE_TOTAL = 2 * LEAVES;
   localparam int NODE_BITS  = $clog2(NODE_TOTAL);

   localparam int ACTION_W = 2;
   localparam int KEY_W    = 11;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 32;
   localparam int SUM_W    = 64;

   localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LARGER  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SMALLER = 2'd2;

   localparam logic [KEY_W-1:0] ACTIVE_KEYS_RESET = 11'd1024;

   typedef struct packed {
      logic [COUNT_W-1:0]      count;
      logic signed [SUM_W-1:0] sum;
   } node_type;

   localparam int NODE_W = $bits(node_type);

endpackage

// ----- rtl/ostcs_req_if.sv -----
// ostcs_req_if: request channel, one insert or query transaction.
// Depends on ostcs_pkg.

interface ostcs_req_if;
   import ostcs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic [KEY_W-1:0]          key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output action, output key, output value, input ready);
   modport sink   (input valid, input action, input key, input value, output ready);
endinterface

// ----- rtl/ostcs_rsp_if.sv -----
// ostcs_rsp_if: response channel, count and sum of one query.
// Depends on ostcs_pkg.

interface ostcs_rsp_if;
   import ostcs_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [COUNT_W-1:0]      match_count;
   logic signed [SUM_W-1:0] match_sum;

   modport source (output valid, output match_count, output match_sum, input ready);
   modport sink   (input valid, input match_count, input match_sum, output ready);
endinterface

// ----- rtl/ostcs_csr_if.sv -----
// ostcs_csr_if: register write channel carrying active_keys.
// Depends on ostcs_pkg.

interface ostcs_csr_if;
   import ostcs_pkg::*;

   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] active_keys;

   modport source (output valid, output active_keys, input ready);
   modport sink   (input valid, input active_keys, output ready);
endinterface

// ----- rtl/ostcs_ram.sv -----
// ostcs_ram: generic simple dual port ram, one write and one registered read.
// No dependencies.

module ostcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/ostcs_sat_add.sv -----
// ostcs_sat_add: shared saturating adder for node records, unsigned count
// and signed sum. Depends on ostcs_pkg.

module ostcs_sat_add (
   input  ostcs_pkg::node_type a,
   input  ostcs_pkg::node_type b,
   output ostcs_pkg::node_type y
);
   import ostcs_pkg::*;

   logic [COUNT_W:0]        count_wide;
   logic signed [SUM_W-1:0] sum_raw;
   logic                    sum_ovf;

   always_comb begin
      count_wide = {1'b0, a.count} + {1'b0, b.count};
      sum_raw    = a.sum + b.sum;
      sum_ovf    = (a.sum[SUM_W-1] == b.sum[SUM_W-1]) && (sum_raw[SUM_W-1] != a.sum[SUM_W-1]);

      y.count = count_wide[COUNT_W] ? {COUNT_W{1'b1}} : count_wide[COUNT_W-1:0];
      if (!sum_ovf) begin
         y.sum = sum_raw;
      end else if (a.sum[SUM_W-1]) begin
         y.sum = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         y.sum = {1'b0, {(SUM_W-1){1'b1}}};
      end
   end
endmodule

// ----- rtl/order_statistic_count_sum_tree.sv -----
// order_statistic_count_sum_tree: an insert walks leaf to root one node per cycle
// (read-modify-write on the node ram); a query reads one sibling per level and
// accumulates, then loads the response register, waiting in its output state while the
// previous response waits. req ready only when the sequencer is idle.
// Synchronous reset, then a clearing pass over every node before the first request; csr writes
// at any time. Depends on ostcs_pkg, ostcs_*_if, ostcs_ram, ostcs_sat_add.

module order_statistic_count_sum_tree (
   input  logic        clock,
   input  logic        reset,
   ostcs_req_if.sink   req_ch,
   ostcs_rsp_if.source rsp_ch,
   ostcs_csr_if.sink   csr_ch
);
   import ostcs_pkg::*;

   localparam int          ST_W      = 3;
   localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
   localparam logic [ST_W-1:0] ST_INS    = 3'd2;
   localparam logic [ST_W-1:0] ST_QRY    = 3'd3;
   localparam logic [ST_W-1:0] ST_QDRAIN = 3'd4;
   localparam logic [ST_W-1:0] ST_OUT    = 3'd5;

   logic [ST_W-1:0]           state_ff, state_in;
   logic [NODE_BITS-1:0]      clr_ff, clr_in;
   logic [NODE_BITS-1:0]      idx_ff, idx_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      larger_ff, larger_in;
   logic                      take_ff, take_in;
   node_type                  acc_ff, acc_in;
   logic [KEY_W-1:0]          active_keys_ff, active_keys_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;

   logic                      wr_en;
   logic [NODE_BITS-1:0]      wr_addr;
   node_type                  wr_data;
   logic [NODE_BITS-1:0]      rd_addr;
   node_type                  rd_data;
   node_type                  add_a, add_b, add_y;

   logic                      req_fire;
   logic [NODE_BITS-1:0]      leaf_idx;
   logic                      key_over;
   logic                      insert_ok;

   ostcs_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_TOTAL)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ostcs_sat_add u_sat_add (
      .a (add_a),
      .b (add_b),
      .y (add_y)
   );

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.match_count = rsp_count_ff;
   assign rsp_ch.match_sum   = rsp_sum_ff;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign leaf_idx  = NODE_BITS'(32'(LEAVES - 1) + 32'(req_ch.key));
   assign key_over  = 32'(req_ch.key) > 32'(LEAVES);
   assign insert_ok = (req_ch.key != '0) && (req_ch.key <= active_keys_ff) && !key_over;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      idx_in         = idx_ff;
      value_in       = value_ff;
      larger_in      = larger_ff;
      take_in        = 1'b0;
      acc_in         = acc_ff;
      active_keys_in = active_keys_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_sum_in     = rsp_sum_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = add_y;
      rd_addr        = idx_ff;
      add_a          = acc_ff;
      add_b          = rd_data;

      if (csr_ch.valid) begin
         active_keys_in = csr_ch.active_keys;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + NODE_BITS'(1);
            if (clr_ff == {NODE_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               acc_in    = '0;
               value_in  = req_ch.value;
               idx_in    = leaf_idx;
               rd_addr   = leaf_idx;
               larger_in = (req_ch.action == ACT_LARGER);
               case (req_ch.action)
                  ACT_INSERT: begin
                     if (insert_ok) begin
                        state_in = ST_INS;
                     end
                  end
                  ACT_LARGER: begin
                     if ((req_ch.key >= active_keys_ff) || key_over) begin
                        state_in = ST_OUT;
                     end else if (req_ch.key == '0) begin
                        rd_addr  = NODE_BITS'(1);
                        take_in  = 1'b1;
                        state_in = ST_QDRAIN;
                     end else begin
                        state_in = ST_QRY;
                     end
                  end
                  ACT_SMALLER: begin
                     if (req_ch.key <= KEY_W'(1)) begin
                        state_in = ST_OUT;
                     end else if (key_over) begin
                        rd_addr  = NODE_BITS'(1);
                        take_in  = 1'b1;
                        state_in = ST_QDRAIN;
                     end else begin
                        state_in = ST_QRY;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INS: begin
            add_a   = rd_data;
            add_b   = '{count: COUNT_W'(1), sum: SUM_W'(value_ff)};
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            rd_addr = idx_ff >> 1;
            idx_in  = idx_ff >> 1;
            if (idx_ff == NODE_BITS'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY: begin
            // sibling read this cycle, previous sibling accumulated
            rd_addr = idx_ff ^ NODE_BITS'(1);
            take_in = larger_ff ? ~idx_ff[0] : idx_ff[0];
            if (take_ff) begin
               acc_in = add_y;
            end
            idx_in = idx_ff >> 1;
            if ((idx_ff >> 1) == NODE_BITS'(1)) begin
               state_in = ST_QDRAIN;
            end
         end
         ST_QDRAIN: begin
            if (take_ff) begin
               acc_in = add_y;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff.count;
               rsp_sum_in   = acc_ff.sum;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         take_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         active_keys_ff <= ACTIVE_KEYS_RESET;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         take_ff        <= take_in;
         rsp_valid_ff   <= rsp_valid_in;
         active_keys_ff <= active_keys_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      value_ff     <= value_in;
      larger_ff    <= larger_in;
      acc_ff       <= acc_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sum_ff   <= rsp_sum_in;
   end
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for order_statistic_count_sum_tree, predicting every
// query response from its own copy of the count/sum tree and active_keys.
// Depends on ostcs_pkg, ostcs_req_if, ostcs_rsp_if, ostcs_csr_if and the dut.

module tb;
   import ostcs_pkg::*;

   localparam int IDLE_LIMIT    = 6000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 125;
   localparam int PHASE_TOTAL   = 9;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] value;
   } tree_request_type;

   logic clock;
   logic reset;

   ostcs_req_if req_ch ();
   ostcs_rsp_if rsp_ch ();
   ostcs_csr_if csr_ch ();

   order_statistic_count_sum_tree dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tree_request_type request_backlog[$];
   node_type         expected_totals[$];

   bit [COUNT_W-1:0]      node_tally [NODE_TOTAL];
   bit signed [SUM_W-1:0] node_total [NODE_TOTAL];
   logic [KEY_W-1:0]      key_limit = ACTIVE_KEYS_RESET;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   int   req_calm = 0;
   int   rsp_calm = 0;
   int   idle_cycles = 0;
   int   insert_total = 0;
   int   query_total = 0;
   int   checked_total = 0;
   int   fail_total = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int idle_draw(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(15, 40);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   function automatic logic [COUNT_W-1:0] count_add(logic [COUNT_W-1:0] a,
                                                    logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] r;
      r = {1'b0, a} + {1'b0, b};
      return r[COUNT_W] ? '1 : r[COUNT_W-1:0];
   endfunction

   function automatic logic signed [SUM_W-1:0] sum_add(logic signed [SUM_W-1:0] a,
                                                       logic signed [SUM_W-1:0] b);
      logic signed [SUM_W-1:0] r;
      r = a + b;
      if (a[SUM_W-1] == b[SUM_W-1] && r[SUM_W-1] != a[SUM_W-1])
         return a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      return r;
   endfunction

   // sibling totals on one side of the leaf, gathered on the way to the root
   function automatic node_type side_totals(int unsigned k, bit larger);
      node_type    acc;
      int unsigned idx;
      int unsigned sib;
      acc = '0;
      idx = LEAVES + k - 1;
      while (idx > 1) begin
         sib = 0;
         if (larger && idx[0] == 1'b0)
            sib = idx + 1;
         if (!larger && idx[0] == 1'b1)
            sib = idx - 1;
         if (sib != 0 && sib < NODE_TOTAL) begin
            acc.count = count_add(acc.count, node_tally[sib]);
            acc.sum   = sum_add(acc.sum, node_total[sib]);
         end
         idx = idx >> 1;
      end
      return acc;
   endfunction

   task automatic predict_tree_op(input tree_request_type rq);
      int unsigned k;
      int unsigned idx;
      node_type    res;
      k   = 32'(rq.key);
      res = '0;
      case (rq.action)
         ACT_INSERT: begin
            if (k != 0 && k <= key_limit && k <= LEAVES) begin
               insert_total++;
               idx = LEAVES + k - 1;
               while (idx > 0) begin
                  node_tally[idx] = count_add(node_tally[idx], 1);
                  node_total[idx] = sum_add(node_total[idx], SUM_W'(rq.value));
                  idx = idx >> 1;
               end
            end
            return;
         end
         ACT_LARGER: begin
            if (k >= key_limit || k > LEAVES)
               res = '0;
            else if (k == 0) begin
               res.count = node_tally[1];
               res.sum   = node_total[1];
            end else
               res = side_totals(k, 1'b1);
         end
         ACT_SMALLER: begin
            if (k <= 1)
               res = '0;
            else if (k > LEAVES) begin
               res.count = node_tally[1];
               res.sum   = node_total[1];
            end else
               res = side_totals(k, 1'b0);
         end
         default: return;
      endcase
      query_total++;
      expected_totals.push_back(res);
   endtask

   // monitor: predict on request transactions, check response transactions
   always @(posedge clock) begin : monitor
      tree_request_type seen;
      node_type         want;
      req_fire <= !reset && req_ch.valid && req_ch.ready;
      rsp_fire <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            key_limit = csr_ch.active_keys;
         if (req_ch.valid && req_ch.ready) begin
            seen.action = req_ch.action;
            seen.key    = req_ch.key;
            seen.value  = req_ch.value;
            predict_tree_op(seen);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_totals.size() == 0) begin
               $error("match_count: expected no response, actual %0d (match_sum %0d)",
                      rsp_ch.match_count, rsp_ch.match_sum);
               fail_total++;
            end else begin
               want = expected_totals.pop_front();
               checked_total++;
               if (rsp_ch.match_count !== want.count) begin
                  $error("match_count: expected %0d, actual %0d",
                         want.count, rsp_ch.match_count);
                  fail_total++;
               end
               if (rsp_ch.match_sum !== want.sum) begin
                  $error("match_sum: expected %0d, actual %0d", want.sum, rsp_ch.match_sum);
                  fail_total++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("order_statistic_count_sum_tree regression: fail");
         $finish;
      end
   end

   // driver: request channel, fed from the backlog
   always @(negedge clock) begin : request_driver
      tree_request_type rq;
      if (reset)
         req_ch.valid <= 1'b0;
      else if (!req_ch.valid || req_fire) begin
         if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap      <= req_gap - 1;
         end else if (request_backlog.size() != 0) begin
            rq = request_backlog.pop_front();
            req_ch.action <= rq.action;
            req_ch.key    <= rq.key;
            req_ch.value  <= rq.value;
            req_ch.valid  <= 1'b1;
            req_gap       <= idle_draw(req_calm);
         end else
            req_ch.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin : response_driver
      int d;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         d = rsp_fire ? idle_draw(rsp_calm) : rsp_stall;
         if (d > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    <= d - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_stall    <= 0;
         end
      end
   end

   task automatic queue_item(input logic [ACTION_W-1:0] a, input int k, input int v);
      tree_request_type rq;
      rq.action = a;
      rq.key    = k[KEY_W-1:0];
      rq.value  = v;
      request_backlog.push_back(rq);
   endtask

   task automatic write_active_keys(input int n);
      @(negedge clock);
      csr_ch.active_keys <= n[KEY_W-1:0];
      csr_ch.valid       <= 1'b1;
      do
         @(posedge clock);
      while (!(csr_ch.valid && csr_ch.ready));
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // wait for the backlog and responses to drain, then let an insert finish
   task automatic drain_tree();
      int n;
      n = 0;
      while (n < SETTLE_CYCLES) begin
         @(posedge clock);
         if (request_backlog.size() != 0 || req_ch.valid || expected_totals.size() != 0)
            n = 0;
         else
            n++;
      end
   endtask

   initial begin : stimulus
      int               plan [PHASE_TOTAL];
      int               lim;
      int               counted;
      int               v;
      tree_request_type rq;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_INSERT;
      req_ch.key         = '0;
      req_ch.value       = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.active_keys = ACTIVE_KEYS_RESET;
      reset              = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_active_keys(ACTIVE_KEYS_RESET);
      queue_item(ACT_INSERT, 1, 32'h7fffffff);
      queue_item(ACT_INSERT, 1024, 32'h80000000);
      queue_item(ACT_INSERT, 512, 0);
      queue_item(ACT_INSERT, 0, 5);
      queue_item(ACT_INSERT, 1025, 9);
      queue_item(ACT_INSERT, 2047, 32'hffffffff);
      queue_item(ACT_LARGER, 0, 0);
      queue_item(ACT_LARGER, 1, 0);
      queue_item(ACT_LARGER, 1023, 0);
      queue_item(ACT_LARGER, 1024, 0);
      queue_item(ACT_LARGER, 2047, 32'h55555555);
      queue_item(ACT_SMALLER, 0, 0);
      queue_item(ACT_SMALLER, 1, 0);
      queue_item(ACT_SMALLER, 2, 0);
      queue_item(ACT_SMALLER, 1024, 0);
      queue_item(ACT_SMALLER, 2047, 32'haaaaaaaa);
      queue_item(ACT_UNUSED, 5, 123);
      drain_tree();

      // store survives a register change
      write_active_keys(16);
      queue_item(ACT_INSERT, 17, 32'h00010000);
      queue_item(ACT_INSERT, 16, 32'h00018000);
      queue_item(ACT_LARGER, 16, 0);
      queue_item(ACT_LARGER, 15, 0);
      queue_item(ACT_SMALLER, 17, 0);
      queue_item(ACT_SMALLER, 1025, 0);
      queue_item(ACT_INSERT, 3, -1);
      drain_tree();

      plan = '{1, 2, 5, 64, 1023, 1024, 0, 0, 300};
      plan[6] = $urandom_range(1, 1024);
      plan[7] = $urandom_range(1, 1024);
      for (int p = 0; p < PHASE_TOTAL; p++) begin
         lim = plan[p];
         write_active_keys(lim);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            case ($urandom_range(0, 19))
               0:                rq.action = ACT_UNUSED;
               1, 2, 3, 4, 5, 6,
               7, 8, 9:          rq.action = ACT_INSERT;
               10, 11, 12, 13,
               14:               rq.action = ACT_LARGER;
               default:          rq.action = ACT_SMALLER;
            endcase
            case ($urandom_range(0, 19))
               0:       rq.key = '0;
               1:       rq.key = KEY_W'(1);
               2:       rq.key = KEY_W'(lim);
               3:       rq.key = KEY_W'(lim + 1);
               4:       rq.key = KEY_W'($urandom_range(0, 2047));
               default: rq.key = KEY_W'($urandom_range(1, lim));
            endcase
            case ($urandom_range(0, 9))
               0:          v = 32'h80000000;
               1:          v = 32'h7fffffff;
               2, 3, 4:    v = $urandom_range(0, 131071) - 65536;
               default:    v = $urandom;
            endcase
            rq.value = v;
            request_backlog.push_back(rq);
            if (rq.action == ACT_LARGER || rq.action == ACT_SMALLER ||
                (rq.action == ACT_INSERT && rq.key != 0 && rq.key <= lim))
               counted++;
         end
         drain_tree();
      end

      $display("covered %0d applied inserts and %0d queries, %0d responses checked",
               insert_total, query_total, checked_total);
      $display("across %0d active_keys settings with random idle on both channels",
               PHASE_TOTAL + 2);
      if (fail_total == 0)
         $display("order_statistic_count_sum_tree regression: pass");
      else
         $display("order_statistic_count_sum_tree regression: fail");
      $finish;
   end

endmodule
